### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Fixed payload widths
    localparam int PRIORITY_WIDTH = 16;
    localparam int OCC_WIDTH      = 6;
    localparam int CAPACITY_DEF   = 32;

    // Command codes
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // One input transaction
    typedef struct packed {
        t_cmd                               command;
        logic signed [PRIORITY_WIDTH-1:0]   priority_req;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic signed [PRIORITY_WIDTH-1:0]   removed_priority;
        logic                               removed_valid;
        logic                               insert_dropped;
        logic [OCC_WIDTH-1:0]               occupancy;
    } t_result;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                               ins;
        logic                               rem;
        logic signed [PRIORITY_WIDTH-1:0]   value;
    } t_cell_op;

endpackage

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Top level: bounded priority queue built from a chain of sorted cells.
// The registered result strobe o_done rises in the cycle after a transaction is accepted.
// Throughput: one insert or remove per cycle when not busy; the command is broadcast
// to all cells, each cell comparing against its own value and its neighbor's in that cycle.
// Reset: synchronous, active low; clears the count; busy stays high until r_rdy sets after reset.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  spq_pkg::t_item      i_item,
    output logic                o_busy,
    output logic                o_done,
    output spq_pkg::t_result    o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = spq_pkg::PRIORITY_WIDTH;

    logic                   r_rdy;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_done;
    spq_pkg::t_result       r_result;
    spq_pkg::t_result       n_result;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    spq_pkg::t_cell_op      w_op;
    logic signed [PW-1:0]   w_value [CAPACITY];
    logic [CAPACITY-1:0]    w_occ;

    assign w_accept = i_start && r_rdy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Command decode, gated by full/empty
    always_comb begin
        w_op.value = i_item.priority_req;
        w_op.ins   = w_accept && (i_item.command == spq_pkg::CMD_INSERT) && !w_full;
        w_op.rem   = w_accept && (i_item.command == spq_pkg::CMD_REMOVE) && !w_empty;
    end

    // Cell chain, cell 0 holds the largest value
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_occ[gi] = (CNT_W'(gi) < r_count);
            if (gi == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_op         (w_op),
                    .i_occ        (w_occ[gi]),
                    .i_prev_occ   (1'b0),
                    .i_prev_value ('0),
                    .i_next_value (w_value[gi+1]),
                    .o_value      (w_value[gi])
                );
            end else if (gi == CAPACITY - 1) begin : g_tail
                spq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_op         (w_op),
                    .i_occ        (w_occ[gi]),
                    .i_prev_occ   (w_occ[gi-1]),
                    .i_prev_value (w_value[gi-1]),
                    .i_next_value (w_value[gi]),
                    .o_value      (w_value[gi])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_op         (w_op),
                    .i_occ        (w_occ[gi]),
                    .i_prev_occ   (w_occ[gi-1]),
                    .i_prev_value (w_value[gi-1]),
                    .i_next_value (w_value[gi+1]),
                    .o_value      (w_value[gi])
                );
            end
        end
    endgenerate

    // Next count and result
    always_comb begin
        n_count = r_count;
        if (w_op.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_op.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        n_result.removed_priority = w_op.rem ? w_value[0] : '0;
        n_result.removed_valid    = w_op.rem;
        n_result.insert_dropped   = w_accept && (i_item.command == spq_pkg::CMD_INSERT)
                                    && w_full;
        n_result.occupancy        = spq_pkg::OCC_WIDTH'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy   <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_rdy   <= 1'b1;
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_busy   = !r_rdy;
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_done)
        else $error("missing result strobe");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_result.removed_valid && r_result.insert_dropped))
        else $error("remove and drop flagged together");
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_value[0] >= w_value[1]))
        else $error("head cells out of order");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_accept) && $past(i_rst_n) |-> $stable(r_count))
        else $error("count changed without a transaction");
`endif

endmodule

`default_nettype wire

### rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one value, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire                                        i_clk,
    input  spq_pkg::t_cell_op                          i_op,
    input  wire                                        i_occ,
    input  wire                                        i_prev_occ,
    input  wire signed [spq_pkg::PRIORITY_WIDTH-1:0]   i_prev_value,
    input  wire signed [spq_pkg::PRIORITY_WIDTH-1:0]   i_next_value,
    output logic signed [spq_pkg::PRIORITY_WIDTH-1:0]  o_value
);

    logic signed [spq_pkg::PRIORITY_WIDTH-1:0] r_value;
    logic signed [spq_pkg::PRIORITY_WIDTH-1:0] n_value;
    logic                                      w_keep;
    logic                                      w_take_new;

    // Chain runs largest first; an empty cell counts as below any value
    assign w_keep     = i_occ && (r_value >= i_op.value);
    assign w_take_new = !i_prev_occ || (i_prev_value >= i_op.value);

    always_comb begin
        n_value = r_value;
        if (i_op.ins) begin
            if (!w_keep) begin
                n_value = w_take_new ? i_op.value : i_prev_value;
            end
        end else if (i_op.rem) begin
            // shift toward the head
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire
